[hw/rtl/window_sum_target_search_top_macros.svh]
// Assertion macros for the window sum target search block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef WINDOW_SUM_TARGET_SEARCH_TOP_MACROS_SVH
`define WINDOW_SUM_TARGET_SEARCH_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define WSTS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define WSTS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define WSTS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define WSTS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[hw/rtl/wsts_pkg.sv]
// Shared types, constants and the microcode ROM of the window sum target search.
// Used by the sequencer, the datapath and the top level; no dependencies.
`default_nettype none
package wsts_pkg;

   localparam int unsigned TARGET_W    = 26;
   localparam int unsigned POS_W       = 11;
   localparam int unsigned RSP_TDATA_W = 16;
   localparam int unsigned STEP_W      = 4;

   // microprogram step addresses
   localparam logic [STEP_W-1:0] ST_LOAD    = 4'd0;
   localparam logic [STEP_W-1:0] ST_INIT    = 4'd1;
   localparam logic [STEP_W-1:0] ST_OUTER   = 4'd2;
   localparam logic [STEP_W-1:0] ST_GROW    = 4'd3;
   localparam logic [STEP_W-1:0] ST_ADD_RD  = 4'd4;
   localparam logic [STEP_W-1:0] ST_ADD     = 4'd5;
   localparam logic [STEP_W-1:0] ST_ADD_CHK = 4'd6;
   localparam logic [STEP_W-1:0] ST_SHRINK  = 4'd7;
   localparam logic [STEP_W-1:0] ST_SUB_RD  = 4'd8;
   localparam logic [STEP_W-1:0] ST_SUB     = 4'd9;
   localparam logic [STEP_W-1:0] ST_SKIP    = 4'd10;
   localparam logic [STEP_W-1:0] ST_SUB_CHK = 4'd11;
   localparam logic [STEP_W-1:0] ST_HIT     = 4'd12;
   localparam logic [STEP_W-1:0] ST_MISS    = 4'd13;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_ACCEPT_LAST,
      COND_TARGET_ZERO,
      COND_LEFT_DONE,
      COND_GROW,
      COND_LEFT_LT_RIGHT,
      COND_SUM_EQ,
      COND_SLOT_FREE
   } cond_type;

   typedef struct packed {
      logic ready;
      logic clear;
      logic rd_en;
      logic rd_sel_left;
      logic add;
      logic sub;
      logic inc_left;
      logic inc_right;
      logic emit;
      logic hit;
   } ctrl_type;

   typedef struct packed {
      ctrl_type            ctrl;
      cond_type            cond;
      logic [STEP_W-1:0]   next_t;
      logic [STEP_W-1:0]   next_f;
   } ucode_word_type;

   typedef struct packed {
      logic accept_last;
      logic target_zero;
      logic left_done;
      logic grow;
      logic left_lt_right;
      logic sum_eq;
      logic slot_free;
   } flags_type;

   function automatic ucode_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_word_type w;
      w = '0;
      w.cond   = COND_ALWAYS;
      w.next_t = ST_LOAD;
      w.next_f = ST_LOAD;
      unique case (step)
         ST_LOAD: begin
            w.ctrl.ready = 1'b1;
            w.cond       = COND_ACCEPT_LAST;
            w.next_t     = ST_INIT;
            w.next_f     = ST_LOAD;
         end
         ST_INIT: begin
            w.ctrl.clear = 1'b1;
            w.cond       = COND_TARGET_ZERO;
            w.next_t     = ST_HIT;
            w.next_f     = ST_OUTER;
         end
         ST_OUTER: begin
            w.cond   = COND_LEFT_DONE;
            w.next_t = ST_MISS;
            w.next_f = ST_GROW;
         end
         ST_GROW: begin
            w.cond   = COND_GROW;
            w.next_t = ST_ADD_RD;
            w.next_f = ST_SHRINK;
         end
         ST_ADD_RD: begin
            w.ctrl.rd_en = 1'b1;
            w.next_t     = ST_ADD;
         end
         ST_ADD: begin
            w.ctrl.add       = 1'b1;
            w.ctrl.inc_right = 1'b1;
            w.next_t         = ST_ADD_CHK;
         end
         ST_ADD_CHK: begin
            w.cond   = COND_SUM_EQ;
            w.next_t = ST_HIT;
            w.next_f = ST_GROW;
         end
         ST_SHRINK: begin
            w.cond   = COND_LEFT_LT_RIGHT;
            w.next_t = ST_SUB_RD;
            w.next_f = ST_SKIP;
         end
         ST_SUB_RD: begin
            w.ctrl.rd_en       = 1'b1;
            w.ctrl.rd_sel_left = 1'b1;
            w.next_t           = ST_SUB;
         end
         ST_SUB: begin
            w.ctrl.sub      = 1'b1;
            w.ctrl.inc_left = 1'b1;
            w.next_t        = ST_SUB_CHK;
         end
         ST_SKIP: begin
            w.ctrl.inc_left = 1'b1;
            w.next_t        = ST_SUB_CHK;
         end
         ST_SUB_CHK: begin
            w.cond   = COND_SUM_EQ;
            w.next_t = ST_HIT;
            w.next_f = ST_OUTER;
         end
         ST_HIT: begin
            w.ctrl.emit = 1'b1;
            w.ctrl.hit  = 1'b1;
            w.cond      = COND_SLOT_FREE;
            w.next_t    = ST_LOAD;
            w.next_f    = ST_HIT;
         end
         ST_MISS: begin
            w.ctrl.emit = 1'b1;
            w.cond      = COND_SLOT_FREE;
            w.next_t    = ST_LOAD;
            w.next_f    = ST_MISS;
         end
         default: begin
            w.next_t = ST_LOAD;
         end
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/wsts_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; no package needed.
`default_nettype none
module wsts_ram #(
   parameter int unsigned WIDTH  = 16,
   parameter int unsigned DEPTH  = 1024,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

[hw/rtl/wsts_seq.sv]
// Microcoded sequencer: step counter, control ROM lookup and conditional jump.
// Depends on wsts_pkg for the ROM, the condition codes and the control structs.
`default_nettype none
module wsts_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire wsts_pkg::flags_type  flags,
   output wsts_pkg::ctrl_type        ctrl
);
   import wsts_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   ucode_word_type    word;
   logic              cond_true;

   assign word = ucode_rom(step_ff);

   always_comb begin
      unique case (word.cond)
         COND_ALWAYS:        cond_true = 1'b1;
         COND_ACCEPT_LAST:   cond_true = flags.accept_last;
         COND_TARGET_ZERO:   cond_true = flags.target_zero;
         COND_LEFT_DONE:     cond_true = flags.left_done;
         COND_GROW:          cond_true = flags.grow;
         COND_LEFT_LT_RIGHT: cond_true = flags.left_lt_right;
         COND_SUM_EQ:        cond_true = flags.sum_eq;
         COND_SLOT_FREE:     cond_true = flags.slot_free;
      endcase
   end

   always_comb begin
      ctrl      = word.ctrl;
      // result goes out only once the output slot is free
      ctrl.emit = word.ctrl.emit & cond_true;
      step_in   = cond_true ? word.next_t : word.next_f;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_LOAD;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/wsts_datapath.sv]
// Datapath: element count, window sum and left/right pointers, store addressing, flags.
// Depends on wsts_pkg and the assertion macro header.
`default_nettype none
`include "window_sum_target_search_top_macros.svh"
module wsts_datapath #(
   parameter int unsigned MAX_ELEMENTS = 1024,
   parameter int unsigned VALUE_BITS   = 16,
   localparam int unsigned ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire wsts_pkg::ctrl_type            ctrl,
   input  wire logic                          req_tvalid,
   input  wire logic                          req_tlast,
   input  wire logic                          slot_free,
   input  wire logic [wsts_pkg::TARGET_W-1:0] target,
   input  wire logic [VALUE_BITS-1:0]         rd_data,
   output wsts_pkg::flags_type                flags,
   output logic                               wr_en,
   output logic      [ADDR_W-1:0]             wr_addr,
   output logic                               rd_en,
   output logic      [ADDR_W-1:0]             rd_addr,
   output logic      [wsts_pkg::POS_W-1:0]    start_pos
);
   import wsts_pkg::*;

   localparam int unsigned CNT_W  = $clog2(MAX_ELEMENTS + 1);
   localparam int unsigned SUM_W  = (VALUE_BITS + CNT_W > TARGET_W) ?
                                    VALUE_BITS + CNT_W : TARGET_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic [CNT_W-1:0] right_ff, right_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [SUM_W-1:0] target_ext;
   logic [SUM_W-1:0] elem_ext;
   logic [CNT_W:0]   pos_wide;
   logic             load_en;
   logic             has_room;

   assign target_ext = SUM_W'(target);
   assign elem_ext   = SUM_W'(rd_data);
   assign has_room   = count_ff < CNT_MAX;
   assign load_en    = ctrl.ready & req_tvalid;

   assign wr_en   = load_en & has_room;
   assign wr_addr = count_ff[ADDR_W-1:0];
   assign rd_en   = ctrl.rd_en;
   assign rd_addr = ctrl.rd_sel_left ? left_ff[ADDR_W-1:0] : right_ff[ADDR_W-1:0];

   assign pos_wide  = {1'b0, left_ff} + {{CNT_W{1'b0}}, 1'b1};
   assign start_pos = POS_W'(pos_wide);

   always_comb begin
      flags.accept_last   = req_tvalid & req_tlast;
      flags.target_zero   = (target == '0);
      flags.left_done     = (left_ff >= count_ff);
      flags.grow          = (sum_ff < target_ext) && (right_ff < count_ff);
      flags.left_lt_right = (left_ff < right_ff);
      flags.sum_eq        = (sum_ff == target_ext);
      flags.slot_free     = slot_free;
   end

   always_comb begin
      count_in = count_ff;
      left_in  = left_ff;
      right_in = right_ff;
      sum_in   = sum_ff;
      priority if (ctrl.emit) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
      if (ctrl.clear) begin
         left_in  = '0;
         right_in = '0;
         sum_in   = '0;
      end else begin
         if (ctrl.inc_left) begin
            left_in = left_ff + CNT_W'(1);
         end
         if (ctrl.inc_right) begin
            right_in = right_ff + CNT_W'(1);
         end
         priority if (ctrl.add) begin
            sum_in = sum_ff + elem_ext;
         end else if (ctrl.sub) begin
            sum_in = sum_ff - elem_ext;
         end else begin
            sum_in = sum_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         left_ff  <= '0;
         right_ff <= '0;
         sum_ff   <= '0;
      end else begin
         count_ff <= count_in;
         left_ff  <= left_in;
         right_ff <= right_in;
         sum_ff   <= sum_in;
      end
   end

   `WSTS_ASSERT_IMP(a_right_in_set, clock, reset,
      (ctrl.rd_en && !ctrl.rd_sel_left), (right_ff < count_ff),
      "right pointer read beyond stored set")
   `WSTS_ASSERT_IMP(a_sub_no_wrap, clock, reset,
      ctrl.sub, (sum_ff >= elem_ext),
      "window sum underflow on drop")
   `WSTS_ASSERT_NXT(a_full_holds, clock, reset,
      (load_en && count_ff == CNT_MAX), (count_ff == CNT_MAX),
      "full store count moved on load")

endmodule
`default_nettype wire

[hw/rtl/window_sum_target_search_top.sv]
// Top level of the window sum target search: stream ports, target register, result slot.
// Instantiates wsts_ram, wsts_seq and wsts_datapath; depends on wsts_pkg and the macro header.
//
//  port group  dir  contents (low bit first)
//  req_*       in   tdata: element_value, zero pad; tlast: last_element
//  rsp_*       out  tdata: found, start_position, zero pad
//  csr_*       in   we / wdata: target_sum
//
// Loading takes one cycle per element; req_tready is high only in the load step.
// After the last element the scan runs on one shared adder and one store read port.
// The result waits in an output register; the next set can load while it is stalled.
// Reset is synchronous; element store contents are not cleared.
`default_nettype none
`include "window_sum_target_search_top_macros.svh"
module window_sum_target_search_top #(
   parameter int unsigned MAX_ELEMENTS = 1024,
   parameter int unsigned VALUE_BITS   = 16,
   localparam int unsigned REQ_TDATA_W = ((VALUE_BITS + 7) / 8) * 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [REQ_TDATA_W-1:0]           req_tdata,   // element_value
   input  wire logic                             req_tlast,   // last_element
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [wsts_pkg::RSP_TDATA_W-1:0] rsp_tdata,   // found, start_position
   input  wire logic                             csr_we,
   input  wire logic [wsts_pkg::TARGET_W-1:0]    csr_wdata    // target_sum
);
   import wsts_pkg::*;

   localparam int unsigned ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

   ctrl_type                ctrl;
   flags_type               flags;
   logic [TARGET_W-1:0]     target_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_found_ff;
   logic [POS_W-1:0]        rsp_pos_ff;
   logic                    slot_free;
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic                    rd_en;
   logic [ADDR_W-1:0]       rd_addr;
   logic [VALUE_BITS-1:0]   rd_data;
   logic [POS_W-1:0]        start_pos;

   assign slot_free  = ~rsp_valid_ff | rsp_tready;
   assign req_tready = ctrl.ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - POS_W - 1){1'b0}}, rsp_pos_ff, rsp_found_ff};

   wsts_ram #(
      .WIDTH  (VALUE_BITS),
      .DEPTH  (MAX_ELEMENTS),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_tdata[VALUE_BITS-1:0]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   wsts_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   wsts_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .VALUE_BITS   (VALUE_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .slot_free  (slot_free),
      .target     (target_ff),
      .rd_data    (rd_data),
      .flags      (flags),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .start_pos  (start_pos)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (csr_we) begin
         target_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         priority if (ctrl.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= rsp_valid_ff;
         end
      end
   end

   // payload: load on emit, hold otherwise
   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         rsp_found_ff <= ctrl.hit;
         rsp_pos_ff   <= ctrl.hit ? start_pos : '0;
      end
   end

   `WSTS_ASSERT_IMP(a_emit_slot_free, clock, reset,
      ctrl.emit, (!rsp_valid_ff || rsp_tready),
      "result emitted over a pending transaction")

endmodule
`default_nettype wire

[tb/tb_window_sum_target_search_top.sv]
// Self-checking testbench for window_sum_target_search_top: streams element sets,
// predicts the found flag and window start of each set, and checks every result.
// Depends on wsts_pkg and the window_sum_target_search_top RTL only.
module tb_window_sum_target_search_top;
   timeunit 1ns;
   timeprecision 1ps;
   import wsts_pkg::*;

   localparam int unsigned MAX_ELEMENTS = 1024;
   localparam int unsigned VALUE_BITS   = 16;
   localparam int unsigned VALUE_MAX    = 65535;
   localparam int unsigned REQ_TDATA_W  = ((VALUE_BITS + 7) / 8) * 8;
   localparam logic [TARGET_W-1:0] TARGET_MAX = '1;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT  = 500000;

   typedef logic [VALUE_BITS-1:0] element_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] start_position;
   } window_result_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // element_value
   logic                   req_tlast  = 1'b0; // last_element
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;         // found, start_position, zero pad
   logic                   csr_we     = 1'b0;
   logic [TARGET_W-1:0]    csr_wdata  = '0;   // target_sum

   // mirror of the block state
   element_type         set_store [MAX_ELEMENTS];
   int unsigned         set_count    = 0;
   logic [TARGET_W-1:0] target_model = '0;
   window_result_type   expected_results [$];

   int unsigned cycle_count     = 0;
   int unsigned mismatch_count  = 0;
   int unsigned unexpected_count = 0;
   int unsigned elements_sent   = 0;
   int unsigned results_seen    = 0;
   int unsigned windows_found   = 0;
   int unsigned overflow_drops  = 0;
   int unsigned stall_left      = 0;
   bit          idle_on         = 1'b1;

   window_sum_target_search_top #(
      .MAX_ELEMENTS(MAX_ELEMENTS),
      .VALUE_BITS  (VALUE_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("window_sum_target_search_top verification failed");
         $finish;
      end
   end

   // Two-pointer scan over the stored set; first window with the goal sum wins.
   function automatic window_result_type locate_window(input int unsigned n,
                                                       input logic [TARGET_W-1:0] goal);
      window_result_type r;
      longint unsigned   sum;
      int unsigned       lft;
      int unsigned       rgt;
      r   = '0;
      sum = 0;
      lft = 0;
      rgt = 0;
      if (goal == 0) begin
         r.found          = 1'b1;
         r.start_position = POS_W'(1);
         return r;
      end
      while (lft < n) begin
         while (sum < goal && rgt < n) begin
            sum += set_store[rgt];
            rgt++;
            if (sum == goal) begin
               r.found          = 1'b1;
               r.start_position = POS_W'(lft + 1);
               return r;
            end
         end
         if (lft < rgt) sum -= set_store[lft];
         lft++;
         if (sum == goal) begin
            r.found          = 1'b1;
            r.start_position = POS_W'(lft + 1);
            return r;
         end
      end
      return r;
   endfunction

   function automatic void record_element(input element_type value, input logic last);
      if (set_count < MAX_ELEMENTS) begin
         set_store[set_count] = value;
         set_count++;
      end else begin
         overflow_drops++;
      end
      if (last) begin
         expected_results.push_back(locate_window(set_count, target_model));
         set_count = 0;
      end
   endfunction

   task automatic send_element(input element_type value, input logic last);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'(value);
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      record_element(value, last);
      elements_sent++;
   endtask

   task automatic send_set(input element_type vals [$]);
      foreach (vals[i]) send_element(vals[i], i == vals.size() - 1);
   endtask

   // Hold the sender until every expected result has been handed over.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_target(input logic [TARGET_W-1:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we       <= 1'b0;
      target_model = value;
   endtask

   // Random set; when asked, plant a window that sums to the goal.
   function automatic void build_set(output element_type vals [$], input int unsigned n,
                                     input int unsigned maxv,
                                     input logic [TARGET_W-1:0] goal, input bit plant);
      int unsigned k_min;
      int unsigned k_hi;
      int unsigned k;
      int unsigned p;
      int unsigned rest;
      int unsigned cap;
      int unsigned lo;
      int unsigned hi;
      int unsigned part;
      vals = {};
      repeat (n) vals.push_back(element_type'($urandom_range(0, maxv)));
      k_min = (goal + VALUE_MAX - 1) / VALUE_MAX;
      if (plant && goal != 0 && k_min <= n && k_min <= 6) begin
         k_hi = (k_min + 3 < n) ? k_min + 3 : n;
         k    = $urandom_range(k_min, k_hi);
         p    = $urandom_range(0, n - k);
         rest = goal;
         for (int j = 0; j < k; j++) begin
            cap  = (k - 1 - j) * VALUE_MAX;
            lo   = (rest > cap) ? rest - cap : 0;
            hi   = (rest < VALUE_MAX) ? rest : VALUE_MAX;
            part = $urandom_range(hi, lo);
            vals[p + j] = element_type'(part);
            rest -= part;
         end
      end
   endfunction

   task automatic run_phase(input int unsigned maxv, input int unsigned budget,
                            input bit pause_midway);
      element_type vals [$];
      int unsigned phase_start;
      int unsigned n;
      bit          paused;
      phase_start = elements_sent;
      paused      = 1'b0;
      while (elements_sent - phase_start < budget) begin
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
         build_set(vals, n, maxv, target_model, $urandom_range(0, 4) < 3);
         send_set(vals);
         if (pause_midway && !paused && elements_sent - phase_start > budget / 2) begin
            wait_drained();
            paused = 1'b1;
         end
      end
   endtask

   // Hold tready low for short random bursts.
   always @(posedge clock) begin
      if (idle_on && stall_left == 0 && $urandom_range(0, 4) == 0)
         stall_left = $urandom_range(1, 4);
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      window_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            $error("result transaction with nothing expected: tdata=%h", rsp_tdata);
            unexpected_count++;
         end else begin
            want = expected_results.pop_front();
            if (want.found) windows_found++;
            if (rsp_tdata[0] !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_tdata[0]);
               mismatch_count++;
            end
            if (rsp_tdata[POS_W:1] !== want.start_position) begin
               $error("start_position: expected %0d, got %0d", want.start_position,
                      rsp_tdata[POS_W:1]);
               mismatch_count++;
            end
            if (rsp_tdata[RSP_TDATA_W-1:POS_W+1] !== '0) begin
               $error("tdata pad: expected 0, got %0h", rsp_tdata[RSP_TDATA_W-1:POS_W+1]);
               mismatch_count++;
            end
         end
      end
   end

   // Target left at its reset value of zero: any set hits at position 1.
   task automatic test_reset_target();
      element_type vals [$];
      vals = '{element_type'(7), element_type'(9)};
      send_set(vals);
      vals = '{element_type'(VALUE_MAX)};
      send_set(vals);
   endtask

   task automatic test_single_extremes();
      element_type vals [$];
      write_target(TARGET_W'(VALUE_MAX));
      vals = '{element_type'(VALUE_MAX)};
      send_set(vals);
      vals = '{element_type'(0)};
      send_set(vals);
      vals = '{element_type'(0), element_type'(VALUE_MAX)};
      send_set(vals);
   endtask

   task automatic test_window_positions();
      element_type vals [$];
      write_target(TARGET_W'(10));
      vals = '{element_type'(4), element_type'(3), element_type'(8), element_type'(2),
               element_type'(7), element_type'(1)};
      send_set(vals);
      vals = '{element_type'(1), element_type'(2), element_type'(3)};
      send_set(vals);
      vals = '{element_type'(20), element_type'(10)};
      send_set(vals);
      vals = '{element_type'(11), element_type'(12), element_type'(6), element_type'(4)};
      send_set(vals);
   endtask

   task automatic test_unreachable_extreme();
      element_type vals [$];
      write_target(TARGET_MAX);
      vals = '{element_type'(VALUE_MAX), element_type'(VALUE_MAX), element_type'(0),
               element_type'(VALUE_MAX)};
      send_set(vals);
   endtask

   // Overfill the store; the trailing elements, the last-marked one too, are dropped.
   task automatic test_store_full();
      element_type vals [$];
      write_target(TARGET_W'(12345));
      vals = {};
      repeat (MAX_ELEMENTS - 1) vals.push_back(element_type'(40000));
      repeat (5) vals.push_back(element_type'(12345));
      send_set(vals);
      write_target(TARGET_W'(5));
      vals = {};
      repeat (MAX_ELEMENTS) vals.push_back(element_type'(0));
      repeat (3) vals.push_back(element_type'(5));
      send_set(vals);
   endtask

   task automatic test_small_targets();
      write_target(TARGET_W'($urandom_range(1, 500)));
      run_phase(100, 100, 1'b0);
   endtask

   task automatic test_wide_values();
      write_target(TARGET_W'($urandom_range(1000, 300000)));
      run_phase(VALUE_MAX, 110, 1'b1);
   endtask

   task automatic test_unit_target();
      write_target(TARGET_W'(1));
      run_phase(3, 90, 1'b0);
   endtask

   task automatic test_zero_target_stream();
      write_target('0);
      run_phase(VALUE_MAX, 60, 1'b0);
   endtask

   task automatic test_max_target_stream();
      write_target(TARGET_MAX);
      run_phase(VALUE_MAX, 70, 1'b0);
   endtask

   task automatic test_random_targets();
      logic [TARGET_W-1:0] goal;
      repeat (8) begin
         goal = ($urandom_range(0, 1) == 0) ? TARGET_W'($urandom_range(1, 300000))
                                            : TARGET_W'($urandom_range(0, TARGET_MAX));
         write_target(goal);
         run_phase(VALUE_MAX, 20, 1'b0);
      end
   endtask

   task automatic test_unstalled_tail();
      wait_drained();
      idle_on = 1'b0;
      write_target(TARGET_W'($urandom_range(1, 2000)));
      run_phase(400, 60, 1'b0);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_target();
      test_single_extremes();
      test_window_positions();
      test_unreachable_extreme();
      test_store_full();
      test_small_targets();
      test_wide_values();
      test_unit_target();
      test_zero_target_stream();
      test_max_target_stream();
      test_random_targets();
      test_unstalled_tail();

      wait_drained();
      repeat (20) @(posedge clock);
      $display("sent %0d elements, checked %0d set results (%0d with a matching window)",
               elements_sent, results_seen, windows_found);
      $display("targets from 0 to full scale; %0d elements dropped past a full store",
               overflow_drops);
      if (mismatch_count == 0 && unexpected_count == 0 && expected_results.size() == 0) begin
         $display("window_sum_target_search_top verification clean");
      end else begin
         $display("window_sum_target_search_top verification failed");
      end
      $finish;
   end

endmodule
